### rtl/tsd_pkg.sv
`default_nettype none

package tsd_pkg;

    // Field widths
    localparam int RAW_W    = 16;
    localparam int MAG_W    = 11;
    localparam int SCALED_W = 14;
    localparam int THR_W    = 14;
    localparam int SEG_W    = 8;
    localparam int DIGIT_W  = 4;
    localparam int REM_W    = 10;   // remainder below one thousand
    localparam int KILO_W   = 4;    // whole thousands, 0..12

    // Constants
    localparam logic [MAG_W-1:0]    MAG_LIMIT       = 11'd2047;
    localparam logic [SEG_W-1:0]    MINUS_SEG       = 8'h40;
    localparam logic [SEG_W-1:0]    DP_SEG          = 8'h80;
    localparam logic [THR_W-1:0]    THRESHOLD_RESET = 14'd1400;
    localparam logic [SCALED_W-1:0] TEN_THOUSAND    = 14'd10000;
    localparam int                  KILO_MAX        = 12;

    // Common-cathode segment table; codes above nine are blank
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

### rtl/tsd_bcd_split.sv
`default_nettype none

// Splits a remainder below one thousand into three decimal digits
module tsd_bcd_split (
    input  wire logic [tsd_pkg::REM_W-1:0]   rem,
    output logic      [tsd_pkg::DIGIT_W-1:0] hundreds_digit,
    output logic      [tsd_pkg::DIGIT_W-1:0] tens_digit,
    output logic      [tsd_pkg::DIGIT_W-1:0] units_digit
);

    logic [tsd_pkg::REM_W-1:0] rem100;
    logic [6:0]                rem10;

    // Hundreds: parallel compares against multiples of 100, then subtract
    always_comb begin
        hundreds_digit = '0;
        for (int j = 1; j <= 9; j++) begin
            if (rem >= tsd_pkg::REM_W'(j * 100)) begin
                hundreds_digit = tsd_pkg::DIGIT_W'(j);
            end
        end
        rem100 = rem - tsd_pkg::REM_W'(hundreds_digit) * 10'd100;
    end

    // Tens and units from the remainder below one hundred
    always_comb begin
        tens_digit = '0;
        for (int j = 1; j <= 9; j++) begin
            if (rem100 >= tsd_pkg::REM_W'(j * 10)) begin
                tens_digit = tsd_pkg::DIGIT_W'(j);
            end
        end
        rem10       = rem100[6:0] - 7'(tens_digit) * 7'd10;
        units_digit = rem10[tsd_pkg::DIGIT_W-1:0];
    end

endmodule

`default_nettype wire

### rtl/temperature_to_segment_display_unit.sv
// Temperature reading to seven-segment pattern encoder.
// A word accepted into the input register passes through the scale, thousands split and output registers to m_tdata.
// Throughput: one word per cycle while m_tready is high; four register stages (input, scale, thousands
// split, output) each advance independently, so bubbles are squeezed under stall.
// Reset (aresetn low, synchronous): all stages empty, threshold back to 1400.
`default_nettype none

module temperature_to_segment_display_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Threshold register
    input  wire logic        cfg_we,
    input  wire logic [13:0] cfg_wdata,   // alarm_threshold
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] raw_reading
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata      // [7:0] sign_pattern, [15:8] hundreds_pattern,
                                          // [23:16] tens_pattern, [31:24] units_pattern,
                                          // [39:32] tenths_pattern,
                                          // [47:40] hundredths_pattern,
                                          // [61:48] scaled_magnitude, [62] alarm
);

    // ------------------------------------------------------------------
    // Threshold register
    logic [tsd_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tsd_pkg::THRESHOLD_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake
    logic in_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic in_valid_next, s1_valid_next, s2_valid_next, out_valid_next;
    logic ready_out, ready2, ready1, ready0;
    logic adv0, adv1, adv2, s_accept;

    always_comb begin
        ready_out = !out_valid_reg || m_tready;
        ready2    = !s2_valid_reg || ready_out;
        ready1    = !s1_valid_reg || ready2;
        ready0    = !in_valid_reg || ready1;
        adv2      = s2_valid_reg && ready_out;
        adv1      = s1_valid_reg && ready2;
        adv0      = in_valid_reg && ready1;
        s_accept  = s_tvalid && ready0;
    end

    assign s_tready = ready0;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (adv0 ? 1'b0 : in_valid_reg);
        s1_valid_next  = adv0     ? 1'b1 : (adv1 ? 1'b0 : s1_valid_reg);
        s2_valid_next  = adv1     ? 1'b1 : (adv2 ? 1'b0 : s2_valid_reg);
        out_valid_next = adv2     ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0
                                                                        : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    logic [tsd_pkg::RAW_W-1:0] raw_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            raw_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitude, clamp, scale by 25/4 with rounding
    logic                         neg_next;
    logic [tsd_pkg::RAW_W:0]      mag_full;
    logic [tsd_pkg::MAG_W-1:0]    mag;
    logic [15:0]                  mag25;
    logic [tsd_pkg::SCALED_W-1:0] scaled_next;
    logic                         s1_neg_reg;
    logic [tsd_pkg::SCALED_W-1:0] s1_scaled_reg;

    always_comb begin
        neg_next = raw_reg[tsd_pkg::RAW_W-1];
        mag_full = neg_next ? (17'h10000 - {1'b0, raw_reg}) : {1'b0, raw_reg};
        mag      = (mag_full > 17'(tsd_pkg::MAG_LIMIT)) ? tsd_pkg::MAG_LIMIT
                                                       : mag_full[tsd_pkg::MAG_W-1:0];
        // 25*m = 16m + 8m + m, plus 2 for rounding
        mag25       = {1'b0, mag, 4'b0} + {2'b0, mag, 3'b0} + {5'b0, mag} + 16'd2;
        scaled_next = mag25[15:2];
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            s1_neg_reg    <= neg_next;
            s1_scaled_reg <= scaled_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: whole thousands, remainder, alarm compare
    logic [tsd_pkg::KILO_W-1:0]   kilo;
    logic [tsd_pkg::SCALED_W-1:0] kilo_rem;
    logic                         top_next;
    logic [tsd_pkg::DIGIT_W-1:0]  thou_next;
    logic [tsd_pkg::SCALED_W-1:0] low4;
    logic                         alarm_next;

    logic                         s2_neg_reg;
    logic [tsd_pkg::SCALED_W-1:0] s2_scaled_reg;
    logic                         s2_top_reg;
    logic [tsd_pkg::DIGIT_W-1:0]  s2_thou_reg;
    logic [tsd_pkg::REM_W-1:0]    s2_rem_reg;
    logic                         s2_alarm_reg;

    always_comb begin
        kilo = '0;
        for (int k = 1; k <= tsd_pkg::KILO_MAX; k++) begin
            if (s1_scaled_reg >= tsd_pkg::SCALED_W'(k * 1000)) begin
                kilo = tsd_pkg::KILO_W'(k);
            end
        end
        kilo_rem   = s1_scaled_reg - tsd_pkg::SCALED_W'(kilo) * 14'd1000;
        top_next   = (kilo >= 4'd10);
        thou_next  = top_next ? (kilo - 4'd10) : kilo;
        low4       = top_next ? (s1_scaled_reg - tsd_pkg::TEN_THOUSAND) : s1_scaled_reg;
        alarm_next = (low4 > thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s2_neg_reg    <= s1_neg_reg;
            s2_scaled_reg <= s1_scaled_reg;
            s2_top_reg    <= top_next;
            s2_thou_reg   <= thou_next;
            s2_rem_reg    <= kilo_rem[tsd_pkg::REM_W-1:0];
            s2_alarm_reg  <= alarm_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: low digits and segment encode
    logic [tsd_pkg::DIGIT_W-1:0] hund_digit, tens_digit, ones_digit;

    tsd_bcd_split u_bcd_split (
        .rem            (s2_rem_reg),
        .hundreds_digit (hund_digit),
        .tens_digit     (tens_digit),
        .units_digit    (ones_digit)
    );

    logic [63:0] out_data_next;
    logic [63:0] out_data_reg;

    always_comb begin
        out_data_next        = '0;
        out_data_next[7:0]   = s2_neg_reg ? tsd_pkg::MINUS_SEG : 8'h00;
        out_data_next[15:8]  = tsd_pkg::seg_of({3'b0, s2_top_reg});
        out_data_next[23:16] = tsd_pkg::seg_of(s2_thou_reg);
        out_data_next[31:24] = tsd_pkg::seg_of(hund_digit) | tsd_pkg::DP_SEG;
        out_data_next[39:32] = tsd_pkg::seg_of(tens_digit);
        out_data_next[47:40] = tsd_pkg::seg_of(ones_digit);
        out_data_next[61:48] = s2_scaled_reg;
        out_data_next[62]    = s2_alarm_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tdata = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions

    // Input is held off only when every stage holds a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

    // Scaled value stays within the clamped range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[61:48] <= 14'd12794))
        else $error("scaled magnitude out of range");

    // Top digit is only ever zero or one, and matches the scaled value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[15:8] == 8'h06) == (m_tdata[61:48] >= 14'd10000)))
        else $error("hundreds digit disagrees with scaled magnitude");

    // A word moved into the output register shows up as valid next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 |=> out_valid_reg)
        else $error("output stage lost a word");

endmodule

`default_nettype wire
